/* sv/ftar_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Command and order codes for the triangular fuzzy number arithmetic block.
// No dependencies; used by fuzzy_triangle_arith_rank.

package ftar_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] order_t;

    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_SUB = 2'd1;
    localparam cmd_t CMD_MUL = 2'd2;
    localparam cmd_t CMD_CMP = 2'd3;

    localparam order_t ORD_LESS    = 2'd0;
    localparam order_t ORD_EQUAL   = 2'd1;
    localparam order_t ORD_GREATER = 2'd2;

endpackage

`default_nettype wire

/* sv/fuzzy_triangle_arith_rank.sv */
`timescale 1ns / 1ps
`default_nettype none
// Triangular fuzzy number add, subtract, multiply and centroid rank compare.
// Depends on ftar_pkg for command and order codes.

// One transfer can be taken on every clock cycle; a stalled output holds the
// whole pipeline in place. An item passes through SW + NW + 9 register stages,
// where SW = max(WORD_BITS, FRAC_BITS + 1) and
// NW = max(2 * WORD_BITS, WORD_BITS + FRAC_BITS). Most of these stages belong
// to the square root unit, one root bit per stage, and the divider, one
// quotient bit per stage, that the rank compare needs.
module fuzzy_triangle_arith_rank #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // a_low, a_mode, a_high, b_low, b_mode, b_high
    input  wire  [((6 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // command
    input  wire  [1:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // res_low, res_mode, res_high, order
    output logic [((3 * WORD_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
    // saturated
    output logic                                     m_tuser
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int RW = (2 * W >= 2 * F + 2) ? 2 * W : 2 * F + 2;
    localparam int SW = RW / 2;
    localparam int NW = (2 * W >= W + F) ? 2 * W : W + F;
    localparam int OUT_BITS = ((3 * W + 2 + 7) / 8) * 8;

    localparam logic [W-1:0]  WMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN     = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  UNIT_LSB = {{(W-1){1'b0}}, 1'b1};
    localparam bit            ONE_OVF  = (F >= W - 1);
    localparam logic [W-1:0]  ONE_W    = ONE_OVF ? WMAX : (UNIT_LSB << F);
    localparam logic [RW-1:0] ONE2     = {{(RW-1){1'b0}}, 1'b1} << (2 * F);

    typedef struct packed {
        ftar_pkg::cmd_t      cmd;
        logic                sat;
        logic [2:0][W-1:0]   r;
        logic [1:0][W-1:0]   d;
        logic [1:0][W-1:0]   l;
        logic [1:0][W-1:0]   m;
        logic [1:0][W-1:0]   u;
    } sq_side_t;

    typedef struct packed {
        ftar_pkg::cmd_t      cmd;
        logic                sat;
        logic [2:0][W-1:0]   r;
        logic [1:0][W-1:0]   m;
        logic [1:0][W-1:0]   z;
        logic [1:0]          xneg;
        logic [1:0]          yneg;
    } dv_side_t;

    function automatic logic [W:0] clip(input logic [W:0] v);
        logic          ovf;
        logic [W-1:0]  val;
        ovf = v[W] ^ v[W-1];
        val = ovf ? (v[W] ? WMIN : WMAX) : v[W-1:0];
        return {ovf, val};
    endfunction

    function automatic logic [W:0] add_w(input logic [W-1:0] a, input logic [W-1:0] b);
        return clip({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic [W:0] sub_w(input logic [W-1:0] a, input logic [W-1:0] b);
        return clip({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] absw(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W:0] clamp_mag(input logic neg, input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        logic          ovf;
        logic [W-1:0]  low;
        logic [W:0]    res;
        lim = NW'(WMAX) + NW'(neg);
        ovf = mag > lim;
        low = mag[W-1:0];
        if (ovf)
        begin
            res = {1'b1, neg ? WMIN : WMAX};
        end
        else
        begin
            res = {1'b0, neg ? (~low + 1'b1) : low};
        end
        return res;
    endfunction

    function automatic logic [2:0][W-1:0] sort3(input logic [2:0][W-1:0] v);
        logic [2:0][W-1:0] s;
        logic [W-1:0]      t;
        s = v;
        if ($signed(s[0]) > $signed(s[1]))
        begin
            t = s[0]; s[0] = s[1]; s[1] = t;
        end
        if ($signed(s[1]) > $signed(s[2]))
        begin
            t = s[1]; s[1] = s[2]; s[2] = t;
        end
        if ($signed(s[0]) > $signed(s[1]))
        begin
            t = s[0]; s[0] = s[1]; s[1] = t;
        end
        return s;
    endfunction

    logic adv;

    // input stage
    logic                   v1_reg;
    ftar_pkg::cmd_t         cmd1_reg;
    logic [1:0][2:0][W-1:0] bnd1_reg;

    // differences, arithmetic, raw products
    logic                    v2_reg;
    ftar_pkg::cmd_t          cmd2_reg;
    logic [1:0][2:0][W-1:0]  bnd2_reg;
    logic                    sat2_reg, sat2_next;
    logic [2:0][W-1:0]       r2_reg, r2_next;
    logic [2:0][2*W-1:0]     prod2_reg, prod2_next;
    logic [2:0]              pneg2_reg, pneg2_next;
    logic [1:0][W-1:0]       d2_reg, d2_next, p2_reg, p2_next, q2_reg, q2_next;
    logic [2:0][W-1:0]       ua, ub;

    // squares, multiply clamp
    logic                    v3_reg;
    ftar_pkg::cmd_t          cmd3_reg;
    logic                    sat3_reg, sat3_next;
    logic [2:0][W-1:0]       r3_reg, r3_next;
    logic [1:0][2*W-1:0]     sqp3_reg, sqp3_next, sqq3_reg, sqq3_next;
    logic [1:0][W-1:0]       d3_reg, l3_reg, m3_reg, u3_reg;
    logic [1:0][W-1:0]       pa3, qa3;

    // square root stages
    logic [SW:0]     sv_reg;
    logic [RW-1:0]   srad_reg  [0:SW][0:3];
    logic [RW-1:0]   srad_next [0:SW][0:3];
    logic [SW+1:0]   srem_reg  [0:SW][0:3];
    logic [SW+1:0]   srem_next [0:SW][0:3];
    logic [SW-1:0]   sroot_reg [0:SW][0:3];
    logic [SW-1:0]   sroot_next[0:SW][0:3];
    sq_side_t        sside_reg [0:SW];
    sq_side_t        sside_next[0:SW];

    // centroid sums and products
    logic                  cv_reg;
    sq_side_t              cside_reg, cside_next;
    logic [1:0][W-1:0]     z1_reg, z1_next, sqc_reg, sqc_next;
    logic [1:0][2*W-1:0]   pd_reg, pd_next, pl_reg, pl_next, pu_reg, pu_next;

    // divider stages
    logic [NW:0]     dv_reg;
    logic [NW-1:0]   dnum_reg  [0:NW][0:3];
    logic [NW-1:0]   dnum_next [0:NW][0:3];
    logic [W-1:0]    drem_reg  [0:NW][0:3];
    logic [W-1:0]    drem_next [0:NW][0:3];
    logic [NW-1:0]   dquo_reg  [0:NW][0:3];
    logic [NW-1:0]   dquo_next [0:NW][0:3];
    dv_side_t        dside_reg [0:NW];
    dv_side_t        dside_next[0:NW];

    // rank terms
    logic                pv1_reg, pv2_reg;
    dv_side_t            pside1_reg, pside1_next, pside2_reg, pside2_next;
    logic [1:0][W-1:0]   x1_reg, x1_next, y1_reg, y1_next;
    logic [1:0][W-1:0]   t0_reg, t0_next, t1_reg, t1_next;

    // output register
    logic                mv_reg;
    logic [OUT_BITS-1:0] mdata_reg, mdata_next;
    logic                muser_reg, muser_next;

    assign adv      = !mv_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // differences and the arithmetic commands
    always_comb
    begin
        logic [W:0] t;
        logic       arith_ovf;
        logic       rank_ovf;
        arith_ovf = 1'b0;
        rank_ovf  = ONE_OVF;
        r2_next   = '0;
        for (int i = 0; i < 3; i++)
        begin
            ua[i]         = absw(bnd1_reg[0][i]);
            ub[i]         = absw(bnd1_reg[1][i]);
            prod2_next[i] = ua[i] * ub[i];
            pneg2_next[i] = bnd1_reg[0][i][W-1] ^ bnd1_reg[1][i][W-1];
        end
        unique case (cmd1_reg)
            ftar_pkg::CMD_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t          = add_w(bnd1_reg[0][i], bnd1_reg[1][i]);
                    r2_next[i] = t[W-1:0];
                    arith_ovf  = arith_ovf | t[W];
                end
            end
            ftar_pkg::CMD_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t          = sub_w(bnd1_reg[0][i], bnd1_reg[1][2-i]);
                    r2_next[i] = t[W-1:0];
                    arith_ovf  = arith_ovf | t[W];
                end
            end
            ftar_pkg::CMD_MUL, ftar_pkg::CMD_CMP:
            begin
                r2_next = '0;
            end
            default:
            begin
                r2_next = '0;
            end
        endcase
        for (int k = 0; k < 2; k++)
        begin
            t          = sub_w(bnd1_reg[k][2], bnd1_reg[k][0]);
            d2_next[k] = t[W-1:0];
            rank_ovf   = rank_ovf | t[W];
            t          = sub_w(bnd1_reg[k][2], bnd1_reg[k][1]);
            p2_next[k] = t[W-1:0];
            rank_ovf   = rank_ovf | t[W];
            t          = sub_w(bnd1_reg[k][1], bnd1_reg[k][0]);
            q2_next[k] = t[W-1:0];
            rank_ovf   = rank_ovf | t[W];
        end
        sat2_next = (cmd1_reg == ftar_pkg::CMD_CMP) ? rank_ovf : arith_ovf;
    end

    // multiply clamp and squares
    always_comb
    begin
        logic [W:0] t;
        logic       mul_ovf;
        mul_ovf = 1'b0;
        r3_next = r2_reg;
        for (int i = 0; i < 3; i++)
        begin
            t = clamp_mag(pneg2_reg[i], NW'(prod2_reg[i] >> F));
            if (cmd2_reg == ftar_pkg::CMD_MUL)
            begin
                r3_next[i] = t[W-1:0];
                mul_ovf    = mul_ovf | t[W];
            end
        end
        sat3_next = sat2_reg | mul_ovf;
        for (int k = 0; k < 2; k++)
        begin
            pa3[k]       = absw(p2_reg[k]);
            qa3[k]       = absw(q2_reg[k]);
            sqp3_next[k] = pa3[k] * pa3[k];
            sqq3_next[k] = qa3[k] * qa3[k];
        end
    end

    // radicands, sort, and the square root stages
    always_comb
    begin
        logic [SW+1:0] rs;
        logic [SW+1:0] tr;
        for (int k = 0; k < 2; k++)
        begin
            srad_next[0][2*k]   = RW'(sqp3_reg[k]) + ONE2;
            srad_next[0][2*k+1] = RW'(sqq3_reg[k]) + ONE2;
        end
        for (int j = 0; j < 4; j++)
        begin
            srem_next[0][j]  = '0;
            sroot_next[0][j] = '0;
        end
        sside_next[0].cmd = cmd3_reg;
        sside_next[0].sat = sat3_reg;
        sside_next[0].r   = (cmd3_reg == ftar_pkg::CMD_SUB || cmd3_reg == ftar_pkg::CMD_MUL)
                            ? sort3(r3_reg) : r3_reg;
        sside_next[0].d   = d3_reg;
        sside_next[0].l   = l3_reg;
        sside_next[0].m   = m3_reg;
        sside_next[0].u   = u3_reg;
        for (int k = 1; k <= SW; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                rs = {srem_reg[k-1][j][SW-1:0], srad_reg[k-1][j][RW-1 -: 2]};
                tr = {sroot_reg[k-1][j], 2'b01};
                if (rs >= tr)
                begin
                    srem_next[k][j]  = rs - tr;
                    sroot_next[k][j] = {sroot_reg[k-1][j][SW-2:0], 1'b1};
                end
                else
                begin
                    srem_next[k][j]  = rs;
                    sroot_next[k][j] = {sroot_reg[k-1][j][SW-2:0], 1'b0};
                end
                srad_next[k][j] = srad_reg[k-1][j] << 2;
            end
            sside_next[k] = sside_reg[k-1];
        end
    end

    // clamp roots, first divisor sum, numerator products
    always_comb
    begin
        logic [W:0]    t;
        logic [W-1:0]  spc;
        logic          ovf;
        ovf        = 1'b0;
        cside_next = sside_reg[SW];
        for (int k = 0; k < 2; k++)
        begin
            if (sroot_reg[SW][2*k] > SW'(WMAX))
            begin
                spc = WMAX;
                ovf = 1'b1;
            end
            else
            begin
                spc = sroot_reg[SW][2*k][W-1:0];
            end
            if (sroot_reg[SW][2*k+1] > SW'(WMAX))
            begin
                sqc_next[k] = WMAX;
                ovf         = 1'b1;
            end
            else
            begin
                sqc_next[k] = sroot_reg[SW][2*k+1][W-1:0];
            end
            t          = add_w(sside_reg[SW].d[k], spc);
            z1_next[k] = t[W-1:0];
            ovf        = ovf | t[W];
            pd_next[k] = $signed(sside_reg[SW].d[k]) * $signed(sside_reg[SW].m[k]);
            pl_next[k] = $signed(spc) * $signed(sside_reg[SW].l[k]);
            pu_next[k] = $signed(sqc_next[k]) * $signed(sside_reg[SW].u[k]);
        end
        if (sside_reg[SW].cmd == ftar_pkg::CMD_CMP)
        begin
            cside_next.sat = sside_reg[SW].sat | ovf;
        end
    end

    // divisor, numerators, and the divider stages
    always_comb
    begin
        logic [W:0]     t;
        logic [W-1:0]   z;
        logic [2*W+1:0] n;
        logic [2*W+1:0] nabs;
        logic           ovf;
        logic [W-1:0]   rs;
        logic [W-1:0]   zz;
        logic           ge;
        ovf                = 1'b0;
        dside_next[0].cmd  = cside_reg.cmd;
        dside_next[0].r    = cside_reg.r;
        dside_next[0].m    = cside_reg.m;
        for (int k = 0; k < 2; k++)
        begin
            t = add_w(z1_reg[k], sqc_reg[k]);
            z = t[W-1:0];
            ovf = ovf | t[W];
            if (z[W-1] || z == '0)
            begin
                z   = UNIT_LSB;
                ovf = 1'b1;
            end
            n = {{2{pd_reg[k][2*W-1]}}, pd_reg[k]} + {{2{pl_reg[k][2*W-1]}}, pl_reg[k]}
              + {{2{pu_reg[k][2*W-1]}}, pu_reg[k]};
            nabs = n[2*W+1] ? (~n + 1'b1) : n;
            dside_next[0].z[k]    = z;
            dside_next[0].xneg[k] = n[2*W+1];
            dside_next[0].yneg[k] = cside_reg.d[k][W-1];
            dnum_next[0][2*k]     = NW'(nabs);
            dnum_next[0][2*k+1]   = NW'(absw(cside_reg.d[k])) << F;
        end
        dside_next[0].sat = cside_reg.sat | ((cside_reg.cmd == ftar_pkg::CMD_CMP) & ovf);
        for (int j = 0; j < 4; j++)
        begin
            drem_next[0][j] = '0;
            dquo_next[0][j] = '0;
        end
        for (int k = 1; k <= NW; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                zz = dside_reg[k-1].z[j >> 1];
                rs = {drem_reg[k-1][j][W-2:0], dnum_reg[k-1][j][NW-1]};
                ge = rs >= zz;
                drem_next[k][j] = ge ? (rs - zz) : rs;
                dquo_next[k][j] = {dquo_reg[k-1][j][NW-2:0], ge};
                dnum_next[k][j] = dnum_reg[k-1][j] << 1;
            end
            dside_next[k] = dside_reg[k-1];
        end
    end

    // centroid coordinates and rank terms
    always_comb
    begin
        logic [W:0] t;
        logic [W:0] ys;
        logic       ovf1;
        logic       ovf2;
        ovf1        = 1'b0;
        ovf2        = 1'b0;
        pside1_next = dside_reg[NW];
        pside2_next = pside1_reg;
        for (int k = 0; k < 2; k++)
        begin
            t          = clamp_mag(dside_reg[NW].xneg[k], dquo_reg[NW][2*k]);
            x1_next[k] = t[W-1:0];
            ovf1       = ovf1 | t[W];
            t          = clamp_mag(dside_reg[NW].yneg[k], dquo_reg[NW][2*k+1]);
            y1_next[k] = t[W-1:0];
            ovf1       = ovf1 | t[W];
            ys         = {y1_reg[k][W-1], y1_reg[k]} + (W+1)'(y1_reg[k][W-1] & y1_reg[k][0]);
            t          = sub_w(x1_reg[k], ys[W:1]);
            t0_next[k] = t[W-1:0];
            ovf2       = ovf2 | t[W];
            t          = sub_w(ONE_W, y1_reg[k]);
            t1_next[k] = t[W-1:0];
            ovf2       = ovf2 | t[W];
        end
        if (dside_reg[NW].cmd == ftar_pkg::CMD_CMP)
        begin
            pside1_next.sat = dside_reg[NW].sat | ovf1;
        end
        if (pside1_reg.cmd == ftar_pkg::CMD_CMP)
        begin
            pside2_next.sat = pside1_reg.sat | ovf2;
        end
    end

    // compare ranks and form the result
    always_comb
    begin
        ftar_pkg::order_t ord;
        if (t0_reg[0] != t0_reg[1])
        begin
            ord = ($signed(t0_reg[0]) < $signed(t0_reg[1]))
                  ? ftar_pkg::ORD_LESS : ftar_pkg::ORD_GREATER;
        end
        else if (t1_reg[0] != t1_reg[1])
        begin
            ord = ($signed(t1_reg[0]) < $signed(t1_reg[1]))
                  ? ftar_pkg::ORD_LESS : ftar_pkg::ORD_GREATER;
        end
        else if (pside2_reg.m[0] != pside2_reg.m[1])
        begin
            ord = ($signed(pside2_reg.m[0]) < $signed(pside2_reg.m[1]))
                  ? ftar_pkg::ORD_LESS : ftar_pkg::ORD_GREATER;
        end
        else
        begin
            ord = ftar_pkg::ORD_EQUAL;
        end
        mdata_next = '0;
        if (pside2_reg.cmd == ftar_pkg::CMD_CMP)
        begin
            mdata_next[3*W +: 2] = ord;
        end
        else
        begin
            mdata_next[3*W-1:0] = pside2_reg.r;
        end
        muser_next = pside2_reg.sat;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            sv_reg  <= '0;
            cv_reg  <= 1'b0;
            dv_reg  <= '0;
            pv1_reg <= 1'b0;
            pv2_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            sv_reg  <= {sv_reg[SW-1:0], v3_reg};
            cv_reg  <= sv_reg[SW];
            dv_reg  <= {dv_reg[NW-1:0], cv_reg};
            pv1_reg <= dv_reg[NW];
            pv2_reg <= pv1_reg;
            mv_reg  <= pv2_reg;
        end
    end

    // advance the payload; hold it while the output is stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= s_tuser;
            for (int k = 0; k < 2; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    bnd1_reg[k][i] <= s_tdata[(3*k+i)*W +: W];
                end
            end
            cmd2_reg  <= cmd1_reg;
            bnd2_reg  <= bnd1_reg;
            sat2_reg  <= sat2_next;
            r2_reg    <= r2_next;
            prod2_reg <= prod2_next;
            pneg2_reg <= pneg2_next;
            d2_reg    <= d2_next;
            p2_reg    <= p2_next;
            q2_reg    <= q2_next;
            cmd3_reg  <= cmd2_reg;
            sat3_reg  <= sat3_next;
            r3_reg    <= r3_next;
            sqp3_reg  <= sqp3_next;
            sqq3_reg  <= sqq3_next;
            d3_reg    <= d2_reg;
            for (int k = 0; k < 2; k++)
            begin
                l3_reg[k] <= bnd2_reg[k][0];
                m3_reg[k] <= bnd2_reg[k][1];
                u3_reg[k] <= bnd2_reg[k][2];
            end
            for (int k = 0; k <= SW; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    srad_reg[k][j]  <= srad_next[k][j];
                    srem_reg[k][j]  <= srem_next[k][j];
                    sroot_reg[k][j] <= sroot_next[k][j];
                end
                sside_reg[k] <= sside_next[k];
            end
            cside_reg <= cside_next;
            z1_reg    <= z1_next;
            sqc_reg   <= sqc_next;
            pd_reg    <= pd_next;
            pl_reg    <= pl_next;
            pu_reg    <= pu_next;
            for (int k = 0; k <= NW; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    dnum_reg[k][j] <= dnum_next[k][j];
                    drem_reg[k][j] <= drem_next[k][j];
                    dquo_reg[k][j] <= dquo_next[k][j];
                end
                dside_reg[k] <= dside_next[k];
            end
            pside1_reg <= pside1_next;
            x1_reg     <= x1_next;
            y1_reg     <= y1_next;
            pside2_reg <= pside2_next;
            t0_reg     <= t0_next;
            t1_reg     <= t1_next;
            mdata_reg  <= mdata_next;
            muser_reg  <= muser_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3*W +: 2] != ftar_pkg::ORD_LESS) |-> m_tdata[3*W-1:0] == '0)
        else $error("rank result carries nonzero bounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[3*W +: 2]))
        else $error("order code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[0] |-> !dside_reg[0].z[0][W-1] && dside_reg[0].z[0] != '0
                      && !dside_reg[0].z[1][W-1] && dside_reg[0].z[1] != '0)
        else $error("divisor not positive");

    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dside_reg[NW]) && $stable(pv2_reg))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

/* sim/tb_fuzzy_triangle_arith_rank.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_triangle_arith_rank: directed and random fuzzy
// number commands under several idle and stall patterns, checked against an in-bench predictor.
// Depends on ftar_pkg and fuzzy_triangle_arith_rank.

module tb_fuzzy_triangle_arith_rank;

    typedef logic signed [31:0]  word_t;
    typedef logic signed [129:0] wide_t;

    typedef struct {
        word_t            lo;
        word_t            md;
        word_t            hi;
        ftar_pkg::order_t ord;
        logic             sat;
    } fuzzy_res_t;

    localparam wide_t WORD_MAX   = 130'sd2147483647;
    localparam wide_t WORD_MIN   = -130'sd2147483648;
    localparam word_t ONE_Q      = 32'sd65536;
    localparam int    CYCLE_LIMIT = 500000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;

    fuzzy_res_t pending_results[$];
    int         error_count;
    int         cycle_count;
    int         send_idle_pct;
    int         stall_pct;
    bit         clamp_hit;

    fuzzy_triangle_arith_rank u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic word_t clamp_word(input wide_t v);
        if (v > WORD_MAX)
        begin
            clamp_hit = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < WORD_MIN)
        begin
            clamp_hit = 1'b1;
            return 32'sh80000000;
        end
        return word_t'(v[31:0]);
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        return clamp_word(wide_t'(a) + wide_t'(b));
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        return clamp_word(wide_t'(a) - wide_t'(b));
    endfunction

    function automatic word_t sat_mul_q(input word_t a, input word_t b);
        return clamp_word((wide_t'(a) * wide_t'(b)) / wide_t'(65536));
    endfunction

    function automatic word_t hyp_root(input word_t p);
        logic [63:0]  mag;
        logic [127:0] n;
        logic [63:0]  r;
        logic [63:0]  c;
        mag = p < 0 ? 64'(-longint'(p)) : 64'(longint'(p));
        n = {64'd0, mag} * {64'd0, mag} + (128'd1 << 32);
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        if (r > 64'd2147483647)
        begin
            clamp_hit = 1'b1;
            return 32'sh7fffffff;
        end
        return word_t'(r[31:0]);
    endfunction

    task automatic centroid_rank(input word_t l, input word_t m, input word_t u,
                                 output word_t t0, output word_t t1, output word_t t2);
        word_t d, p, q, sp, sq, z, x, y;
        wide_t n;
        d  = sat_sub(u, l);
        p  = sat_sub(u, m);
        q  = sat_sub(m, l);
        sp = hyp_root(p);
        sq = hyp_root(q);
        z  = sat_add(sat_add(d, sp), sq);
        if (z < 1)
        begin
            z = 1;
            clamp_hit = 1'b1;
        end
        n  = wide_t'(d) * wide_t'(m) + wide_t'(sp) * wide_t'(l) + wide_t'(sq) * wide_t'(u);
        x  = clamp_word(n / wide_t'(z));
        y  = clamp_word((wide_t'(d) * wide_t'(65536)) / wide_t'(z));
        t0 = sat_sub(x, y / 2);
        t1 = sat_sub(ONE_Q, y);
        t2 = m;
    endtask

    task automatic sort_bounds(inout word_t v0, inout word_t v1, inout word_t v2);
        word_t t;
        if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
        if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
        if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    endtask

    task automatic predict_fuzzy(input ftar_pkg::cmd_t cmd, input logic [191:0] data,
                                 output fuzzy_res_t r);
        word_t a[3];
        word_t b[3];
        word_t ra[3];
        word_t rb[3];
        for (int i = 0; i < 3; i++)
        begin
            a[i] = data[32 * i +: 32];
            b[i] = data[96 + 32 * i +: 32];
        end
        clamp_hit = 1'b0;
        r.lo = 0;
        r.md = 0;
        r.hi = 0;
        r.ord = ftar_pkg::ORD_LESS;
        case (cmd)
            ftar_pkg::CMD_ADD:
            begin
                r.lo = sat_add(a[0], b[0]);
                r.md = sat_add(a[1], b[1]);
                r.hi = sat_add(a[2], b[2]);
            end
            ftar_pkg::CMD_SUB:
            begin
                r.lo = sat_sub(a[0], b[2]);
                r.md = sat_sub(a[1], b[1]);
                r.hi = sat_sub(a[2], b[0]);
                sort_bounds(r.lo, r.md, r.hi);
            end
            ftar_pkg::CMD_MUL:
            begin
                r.lo = sat_mul_q(a[0], b[0]);
                r.md = sat_mul_q(a[1], b[1]);
                r.hi = sat_mul_q(a[2], b[2]);
                sort_bounds(r.lo, r.md, r.hi);
            end
            default:
            begin
                centroid_rank(a[0], a[1], a[2], ra[0], ra[1], ra[2]);
                centroid_rank(b[0], b[1], b[2], rb[0], rb[1], rb[2]);
                r.ord = ftar_pkg::ORD_EQUAL;
                for (int i = 0; i < 3; i++)
                begin
                    if (ra[i] != rb[i])
                    begin
                        r.ord = ra[i] < rb[i] ? ftar_pkg::ORD_LESS : ftar_pkg::ORD_GREATER;
                        break;
                    end
                end
            end
        endcase
        r.sat = clamp_hit;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s: got %h, expected %h", field, got, want);
        error_count++;
    endtask

    task automatic send_item(input ftar_pkg::cmd_t cmd, input word_t al, input word_t am,
                             input word_t ah, input word_t bl, input word_t bm,
                             input word_t bh);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {bh, bm, bl, ah, am, al};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(4))
            0: return word_t'($urandom);
            1: return word_t'($urandom_range(2097152)) - 32'sd1048576;
            2: return word_t'($urandom_range(512)) * ONE_Q - 32'sd256 * ONE_Q;
            3:
            begin
                case ($urandom_range(4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
            default: return word_t'($urandom_range(65535)) - 32'sd32768;
        endcase
    endfunction

    task automatic send_random_item();
        ftar_pkg::cmd_t cmd;
        word_t          v[6];
        cmd = ftar_pkg::cmd_t'($urandom_range(3));
        for (int i = 0; i < 6; i++)
            v[i] = rand_word();
        if ($urandom_range(99) < 75)
        begin
            sort_bounds(v[0], v[1], v[2]);
            sort_bounds(v[3], v[4], v[5]);
        end
        if (cmd == ftar_pkg::CMD_CMP && $urandom_range(99) < 20)
        begin
            v[3] = v[0];
            v[4] = v[1];
            v[5] = v[2];
        end
        send_item(cmd, v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    always @(posedge clk)
    begin
        fuzzy_res_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_fuzzy(s_tuser, s_tdata, r);
            pending_results.push_back(r);
        end
    end

    always @(posedge clk)
    begin
        fuzzy_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.lo)
                    report_mismatch("res_low", m_tdata[31:0], want.lo);
                if (m_tdata[63:32] !== want.md)
                    report_mismatch("res_mode", m_tdata[63:32], want.md);
                if (m_tdata[95:64] !== want.hi)
                    report_mismatch("res_high", m_tdata[95:64], want.hi);
                if (m_tdata[97:96] !== want.ord)
                    report_mismatch("order", 32'(m_tdata[97:96]), 32'(want.ord));
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", 32'(m_tuser), 32'(want.sat));
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= $urandom_range(99) >= stall_pct;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_add();
        send_item(ftar_pkg::CMD_ADD, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh7fffffff, 1, 0);
        send_item(ftar_pkg::CMD_ADD, 32'sh80000000, -1, 5, 32'sh80000000, 32'sh80000000, -5);
        send_item(ftar_pkg::CMD_ADD, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, -ONE_Q, ONE_Q, 4 * ONE_Q);
    endtask

    task automatic test_sub();
        send_item(ftar_pkg::CMD_SUB, 32'sh80000000, 0, 32'sh7fffffff,
                  32'sh80000000, 0, 32'sh7fffffff);
        send_item(ftar_pkg::CMD_SUB, 3 * ONE_Q, ONE_Q, -ONE_Q, 2, 7, -9);
        send_item(ftar_pkg::CMD_SUB, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_mul();
        send_item(ftar_pkg::CMD_MUL, 32'sh80000000, 32'sh7fffffff, -ONE_Q,
                  32'sh80000000, -1, ONE_Q);
        send_item(ftar_pkg::CMD_MUL, -3, 2 * ONE_Q, 32'sh7fffffff,
                  5, -ONE_Q / 2, 32'sh7fffffff);
        send_item(ftar_pkg::CMD_MUL, -1, 1, 65535, 1, 1, 1);
    endtask

    task automatic test_compare();
        send_item(ftar_pkg::CMD_CMP, 0, 0, 0, 0, 0, 0);
        send_item(ftar_pkg::CMD_CMP, -ONE_Q, 0, ONE_Q, -ONE_Q, 0, ONE_Q);
        send_item(ftar_pkg::CMD_CMP, 0, ONE_Q, 2 * ONE_Q, ONE_Q, 2 * ONE_Q, 3 * ONE_Q);
        send_item(ftar_pkg::CMD_CMP, 3 * ONE_Q, ONE_Q, -2 * ONE_Q, -ONE_Q, 0, ONE_Q);
        send_item(ftar_pkg::CMD_CMP, 32'sh7fffffff, 0, 32'sh80000000, 0, 1, 2);
        send_item(ftar_pkg::CMD_CMP, 32'sh80000000, 0, 32'sh7fffffff,
                  32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_item(ftar_pkg::CMD_CMP, 0, 32'sh7fffffff, 32'sh7fffffff,
                  0, ONE_Q, 32'sh7fffffff);
        send_item(ftar_pkg::CMD_CMP, -5, 0, 5, -5, 1, 5);
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count)
            send_random_item();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ftar_pkg::CMD_ADD;
        m_tready      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_add();
        test_sub();
        test_mul();
        test_compare();
        test_random(240, 0, 0);
        test_random(240, 80, 0);
        test_random(240, 0, 80);
        test_random(230, 17, 17);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
